// ===== rtl/core/ltb_pkg.sv =====
package ltb_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int MAX_LENGTH  = 65535;

    localparam int BRACKET_W = 9;
    localparam int KIND_W    = 8;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 16;
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);

    // The entry on top of the stack lives in the core; the cells hold the rest.
    localparam int NUM_CELLS = STACK_DEPTH - 1;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LENGTH);
    localparam logic [SP_W-1:0]  SP_FULL   = SP_W'(STACK_DEPTH);
    localparam logic [SP_W-1:0]  SP_GUARD  = SP_W'(1);
    localparam logic [KIND_W-1:0] KIND_GUARD = '0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
    } ltb_entry_t;

    localparam ltb_entry_t GUARD_ENTRY = '{kind: KIND_GUARD, pos: '0};

    typedef struct packed {
        logic push;
        logic pop;
    } ltb_shift_t;

    typedef struct packed {
        logic [LEN_W-1:0] longest;
        logic             overflow;
        logic             final_res;
    } ltb_res_t;

endpackage

// ===== rtl/core/ltb_in_if.sv =====
interface ltb_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ltb_pkg::BRACKET_W-1:0] bracket;
    logic                                last;

    modport source (output valid, output bracket, output last, input ready);
    modport sink (input valid, input bracket, input last, output ready);
endinterface

// ===== rtl/core/ltb_out_if.sv =====
interface ltb_out_if;
    logic                        valid;
    logic                        ready;
    logic [ltb_pkg::LEN_W-1:0]   longest;
    logic                        overflow;
    logic                        final_res;

    modport source (output valid, output longest, output overflow, output final_res,
                    input ready);
    modport sink (input valid, input longest, input overflow, input final_res,
                  output ready);
endinterface

// ===== rtl/core/longest_valid_typed_brackets_core.sv =====
// A result enters the result buffer on its item's transfer and is offered from there.
// Throughput: one item per cycle while the buffer is not full; the top of stack
// is held in a register and the rest of the stack is a chain of shift cells.
// A two-entry result buffer keeps input transfers going while a result waits.
// Reset (asynchronous, rst_n low) empties the result buffer and leaves the stack
// holding only its guard, with position, best length and overflow cleared.
module longest_valid_typed_brackets_core (
    input  logic       clk,
    input  logic       rst_n,
    ltb_in_if.sink     tokens,
    ltb_out_if.source  results
);

    ltb_pkg::ltb_entry_t top_reg;
    ltb_pkg::ltb_entry_t top_next;
    logic [ltb_pkg::SP_W-1:0]  sp_reg;
    logic [ltb_pkg::SP_W-1:0]  sp_next;
    logic [ltb_pkg::POS_W-1:0] pos_reg;
    logic [ltb_pkg::POS_W-1:0] pos_next;
    logic [ltb_pkg::LEN_W-1:0] best_reg;
    logic [ltb_pkg::LEN_W-1:0] best_next;
    logic                      ovf_reg;
    logic                      ovf_next;

    ltb_pkg::ltb_entry_t cell_q [ltb_pkg::NUM_CELLS];
    ltb_pkg::ltb_shift_t shift;
    ltb_pkg::ltb_res_t   res;

    logic                      accept;
    logic                      buf_full;
    logic                      pos_at_limit;
    logic [ltb_pkg::POS_W-1:0] pos_item;
    logic                      is_close;
    logic                      is_nonzero;
    logic [ltb_pkg::BRACKET_W-1:0] close_kind;
    logic                      match;
    logic                      push_req;
    logic                      push_ok;
    logic                      pop_ok;
    logic                      ovf_item;
    logic [ltb_pkg::POS_W-1:0] span;
    logic [ltb_pkg::LEN_W-1:0] best_item;
    ltb_pkg::ltb_entry_t       new_entry;

    assign tokens.ready = !buf_full;
    assign accept       = tokens.valid & tokens.ready;

    always_comb
    begin
        pos_at_limit = (pos_reg == ltb_pkg::POS_LIMIT);
        pos_item     = pos_at_limit ? pos_reg : pos_reg + ltb_pkg::POS_W'(1);
        is_close     = tokens.bracket[ltb_pkg::BRACKET_W-1];
        is_nonzero   = (tokens.bracket != '0);
        close_kind   = (~tokens.bracket) + ltb_pkg::BRACKET_W'(1);
        // A close of the most negative code has a kind no open can carry.
        match        = is_close && (sp_reg > ltb_pkg::SP_GUARD) &&
                       ({1'b0, top_reg.kind} == close_kind);
        push_req     = is_nonzero && !match;
        push_ok      = push_req && (sp_reg < ltb_pkg::SP_FULL);
        pop_ok       = is_nonzero && match;
        ovf_item     = ovf_reg | pos_at_limit | (push_req & !push_ok);
        span         = pos_item - cell_q[0].pos;
        best_item    = (pop_ok && (span > best_reg)) ? span : best_reg;

        new_entry.kind = is_close ? ltb_pkg::KIND_GUARD
                                  : tokens.bracket[ltb_pkg::KIND_W-1:0];
        new_entry.pos  = pos_item;
    end

    always_comb
    begin
        top_next   = top_reg;
        sp_next    = sp_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        shift.push = 1'b0;
        shift.pop  = 1'b0;
        if (accept)
        begin
            if (tokens.last)
            begin
                top_next  = ltb_pkg::GUARD_ENTRY;
                sp_next   = ltb_pkg::SP_GUARD;
                pos_next  = '0;
                best_next = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                pos_next   = pos_item;
                best_next  = best_item;
                ovf_next   = ovf_item;
                shift.push = push_ok;
                shift.pop  = pop_ok;
                if (push_ok)
                begin
                    top_next = new_entry;
                    sp_next  = sp_reg + ltb_pkg::SP_W'(1);
                end
                else if (pop_ok)
                begin
                    top_next = cell_q[0];
                    sp_next  = sp_reg - ltb_pkg::SP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= ltb_pkg::GUARD_ENTRY;
            sp_reg   <= ltb_pkg::SP_GUARD;
            pos_reg  <= '0;
            best_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            top_reg  <= top_next;
            sp_reg   <= sp_next;
            pos_reg  <= pos_next;
            best_reg <= best_next;
            ovf_reg  <= ovf_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ltb_pkg::NUM_CELLS; gi++)
        begin : g_cell
            ltb_pkg::ltb_entry_t up_entry;
            ltb_pkg::ltb_entry_t down_entry;

            if (gi == 0)
            begin : g_first
                assign up_entry = top_reg;
            end
            else
            begin : g_mid_up
                assign up_entry = cell_q[gi-1];
            end

            if (gi == ltb_pkg::NUM_CELLS - 1)
            begin : g_last
                assign down_entry = '0;
            end
            else
            begin : g_mid_down
                assign down_entry = cell_q[gi+1];
            end

            ltb_cell u_cell (
                .clk       (clk),
                .ctrl      (shift),
                .from_up   (up_entry),
                .from_down (down_entry),
                .entry     (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        res.longest   = best_item;
        res.overflow  = ovf_item;
        res.final_res = tokens.last;
    end

    ltb_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (buf_full),
        .results   (results)
    );

`ifndef ASSERT_OFF
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg >= ltb_pkg::SP_GUARD) && (sp_reg <= ltb_pkg::SP_FULL))
        else $error("stack pointer out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tokens.last) |=>
            (sp_reg == ltb_pkg::SP_GUARD) && (pos_reg == '0) && (best_reg == '0) &&
            (top_reg == ltb_pkg::GUARD_ENTRY))
        else $error("sequence state not cleared after the final transfer");

    a_pop_above_guard: assert property (@(posedge clk) disable iff (!rst_n)
        shift.pop |-> (sp_reg > ltb_pkg::SP_GUARD) && !shift.push)
        else $error("pop of the guard or push and pop together");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !tokens.last) |=> (best_reg >= $past(best_reg)))
        else $error("best length decreased within a sequence");
`endif

endmodule

// ===== rtl/core/ltb_cell.sv =====
module ltb_cell (
    input  logic                clk,
    input  ltb_pkg::ltb_shift_t ctrl,
    input  ltb_pkg::ltb_entry_t from_up,
    input  ltb_pkg::ltb_entry_t from_down,
    output ltb_pkg::ltb_entry_t entry
);

    ltb_pkg::ltb_entry_t entry_reg;
    ltb_pkg::ltb_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = from_up;
        end
        else if (ctrl.pop)
        begin
            entry_next = from_down;
        end
    end

    // Stack payload; entries at or beyond the stack pointer are never read.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/ltb_res_buf.sv =====
module ltb_res_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ltb_pkg::ltb_res_t push_data,
    output logic              full,
    ltb_out_if.source         results
);

    ltb_pkg::ltb_res_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    assign pop  = results.valid & results.ready;
    assign full = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign results.valid     = (count_reg != 2'd0);
    assign results.longest   = slot_reg[rd_ptr_reg].longest;
    assign results.overflow  = slot_reg[rd_ptr_reg].overflow;
    assign results.final_res = slot_reg[rd_ptr_reg].final_res;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result written into a full buffer");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer pointers disagree with the count");
`endif

endmodule
